// ===== hw/rtl/lgl_pkg.sv =====
// shared types, widths and codes for the linear gradient lookup
// no dependencies; every other file imports this package
`timescale 1ns / 1ps
`default_nettype none

package lgl_pkg;

    localparam int LGL_RAMP_LENGTH = 1024;

    localparam int COLOR_W    = 32;
    localparam int INDEX_W    = 10;
    localparam int COORD_W    = 16;
    localparam int STEP_W     = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + STEP_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = ACC_W - FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_MODE = 3'd4;

    // input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // spread modes
    localparam logic [MODE_W-1:0] SPREAD_PAD     = 2'd0;
    localparam logic [MODE_W-1:0] SPREAD_REFLECT = 2'd1;
    localparam logic [MODE_W-1:0] SPREAD_REPEAT  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [STEP_W-1:0]  step_x;
        logic [STEP_W-1:0]  step_y;
        logic [MODE_W-1:0]  spread_mode;
    } lgl_cfg_t;

    // fields that ride along the pipeline with each transaction
    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] ramp_index;
        logic [COLOR_W-1:0] ramp_color;
    } lgl_tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lgl_req_if.sv =====
// request channel: ramp writes and pixel lookups
// depends on lgl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lgl_req_if
    import lgl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [INDEX_W-1:0] ramp_index;
    logic [COLOR_W-1:0] ramp_color;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (
        output valid, opcode, ramp_index, ramp_color, pixel_x, pixel_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, ramp_index, ramp_color, pixel_x, pixel_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/lgl_rsp_if.sv =====
// response channel: looked-up colour and the index used
// depends on lgl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lgl_rsp_if
    import lgl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [INDEX_W-1:0] used_index;

    modport source (
        output valid, pixel_color, used_index,
        input  ready
    );

    modport sink (
        input  valid, pixel_color, used_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/linear_gradient_lookup.sv =====
// linear gradient lookup: one transaction per cycle sustained while the response
// is taken; the stages are offset, multiply, sum, spread map and ramp read, each
// holding its own valid bit, so a stalled response only backs up as far as the
// first empty stage.
// reset clears the configuration registers and all valid bits;
// the colour ramp is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module linear_gradient_lookup
    import lgl_pkg::*;
#(
    parameter int RAMP_LENGTH = LGL_RAMP_LENGTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    lgl_req_if.sink                    req,
    lgl_rsp_if.source                  rsp
);

    localparam int IW = $clog2(RAMP_LENGTH);

    lgl_cfg_t cfg_reg, cfg_next;

    lgl_tag_t      req_tag;
    logic          pos_valid, pos_ready;
    lgl_tag_t      pos_tag;
    logic signed [ACC_W-1:0] pos_acc;
    logic          map_valid, map_ready;
    lgl_tag_t      map_tag;
    logic [IW-1:0] map_addr;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:    cfg_next.origin_x    = cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y:    cfg_next.origin_y    = cfg_data[COORD_W-1:0];
                REG_STEP_X:      cfg_next.step_x      = cfg_data[STEP_W-1:0];
                REG_STEP_Y:      cfg_next.step_y      = cfg_data[STEP_W-1:0];
                REG_SPREAD_MODE: cfg_next.spread_mode = cfg_data[MODE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign req_tag.opcode     = req.opcode;
    assign req_tag.ramp_index = req.ramp_index;
    assign req_tag.ramp_color = req.ramp_color;

    lgl_position u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_tag    (req_tag),
        .pixel_x   (req.pixel_x),
        .pixel_y   (req.pixel_y),
        .out_valid (pos_valid),
        .out_ready (pos_ready),
        .out_tag   (pos_tag),
        .acc       (pos_acc)
    );

    lgl_spread #(
        .RAMP_LENGTH (RAMP_LENGTH)
    ) u_spread (
        .clk         (clk),
        .rst_n       (rst_n),
        .spread_mode (cfg_reg.spread_mode),
        .in_valid    (pos_valid),
        .in_ready    (pos_ready),
        .in_tag      (pos_tag),
        .acc         (pos_acc),
        .out_valid   (map_valid),
        .out_ready   (map_ready),
        .out_tag     (map_tag),
        .ramp_addr   (map_addr)
    );

    lgl_ramp #(
        .RAMP_LENGTH (RAMP_LENGTH)
    ) u_ramp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (map_valid),
        .in_ready    (map_ready),
        .in_tag      (map_tag),
        .ramp_addr   (map_addr),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .pixel_color (rsp.pixel_color),
        .used_index  (rsp.used_index)
    );

    // with the output register free every stage can move
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid)
        else $error("input stalled while the response register is empty");

    a_cfg_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index != REG_ORIGIN_X && cfg_index != REG_ORIGIN_Y
            && cfg_index != REG_STEP_X && cfg_index != REG_STEP_Y
            && cfg_index != REG_SPREAD_MODE) |=> $stable(cfg_reg))
        else $error("write to an unmapped index changed configuration");

    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(cfg_reg))
        else $error("configuration changed without a write");

endmodule

`default_nettype wire

// ===== hw/rtl/lgl_position.sv =====
// position pipeline: offsets, two multiplies, sum into signed Q34.16
// three register stages; depends on lgl_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgl_position
    import lgl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lgl_cfg_t                cfg,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire lgl_tag_t                in_tag,
    input  wire logic [COORD_W-1:0]      pixel_x,
    input  wire logic [COORD_W-1:0]      pixel_y,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output lgl_tag_t                     out_tag,
    output logic signed [ACC_W-1:0]      acc
);

    logic                     s1_valid_reg, s1_valid_next;
    lgl_tag_t                 s1_tag_reg, s1_tag_next;
    logic signed [DIFF_W-1:0] dx_reg, dx_next;
    logic signed [DIFF_W-1:0] dy_reg, dy_next;

    logic                     s2_valid_reg, s2_valid_next;
    lgl_tag_t                 s2_tag_reg, s2_tag_next;
    logic signed [PROD_W-1:0] px_reg, px_next;
    logic signed [PROD_W-1:0] py_reg, py_next;

    logic                     s3_valid_reg, s3_valid_next;
    lgl_tag_t                 s3_tag_reg, s3_tag_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                     ready1, ready2, ready3;
    logic signed [STEP_W-1:0] step_x, step_y;

    assign step_x = cfg.step_x;
    assign step_y = cfg.step_y;

    // a stage moves when it is empty or the one after it moves
    assign ready3   = !s3_valid_reg || out_ready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_ready = ready1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_tag_next   = s1_tag_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        if (ready1)
        begin
            s1_valid_next = in_valid;
            s1_tag_next   = in_tag;
            dx_next       = $signed({pixel_x[COORD_W-1], pixel_x})
                          - $signed({cfg.origin_x[COORD_W-1], cfg.origin_x});
            dy_next       = $signed({pixel_y[COORD_W-1], pixel_y})
                          - $signed({cfg.origin_y[COORD_W-1], cfg.origin_y});
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_tag_next   = s2_tag_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        if (ready2)
        begin
            s2_valid_next = s1_valid_reg;
            s2_tag_next   = s1_tag_reg;
            px_next       = dx_reg * step_x;
            py_next       = dy_reg * step_y;
        end
    end

    always_comb
    begin
        s3_valid_next = s3_valid_reg;
        s3_tag_next   = s3_tag_reg;
        acc_next      = acc_reg;
        if (ready3)
        begin
            s3_valid_next = s2_valid_reg;
            s3_tag_next   = s2_tag_reg;
            acc_next      = ACC_W'(px_reg) + ACC_W'(py_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= s1_tag_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        s2_tag_reg <= s2_tag_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        s3_tag_reg <= s3_tag_next;
        acc_reg    <= acc_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_tag   = s3_tag_reg;
    assign acc       = acc_reg;

    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && ready2) |=> s2_valid_reg)
        else $error("stage 1 transaction lost on its way to stage 2");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !ready3) |=> (s2_valid_reg && $stable(px_reg) && $stable(py_reg)))
        else $error("stalled products changed");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !out_ready) |=> (s3_valid_reg && $stable(acc_reg)))
        else $error("stalled sum changed");

endmodule

`default_nettype wire

// ===== hw/rtl/lgl_spread.sv =====
// truncation toward zero and spread mapping to a ramp index
// one register stage; depends on lgl_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgl_spread
    import lgl_pkg::*;
#(
    parameter int RAMP_LENGTH = LGL_RAMP_LENGTH,
    localparam int IW = $clog2(RAMP_LENGTH)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [MODE_W-1:0]       spread_mode,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire lgl_tag_t                in_tag,
    input  wire logic signed [ACC_W-1:0] acc,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output lgl_tag_t                     out_tag,
    output logic [IW-1:0]                ramp_addr
);

    localparam logic [IW-1:0]    MASK     = IW'(RAMP_LENGTH - 1);
    localparam logic [IW:0]      MASK2    = (IW + 1)'(2 * RAMP_LENGTH - 1);
    localparam logic [POS_W-1:0] PAD_HIGH = POS_W'(RAMP_LENGTH - 1);

    logic             s4_valid_reg, s4_valid_next;
    lgl_tag_t         s4_tag_reg, s4_tag_next;
    logic [IW-1:0]    addr_reg, addr_next;

    logic             neg;
    logic [ACC_W-1:0] biased;
    logic [POS_W-1:0] pos;
    logic [IW:0]      fold;
    logic [IW-1:0]    mapped;

    assign in_ready = !s4_valid_reg || out_ready;

    // adding 2^16-1 to a negative value before the shift rounds toward zero
    assign neg    = acc[ACC_W-1];
    assign biased = $unsigned(acc) + {{(ACC_W - FRAC_W){1'b0}}, {FRAC_W{neg}}};
    assign pos    = biased[ACC_W-1:FRAC_W];
    assign fold   = pos[IW:0] & MASK2;

    always_comb
    begin
        unique case (spread_mode)
            SPREAD_PAD:
            begin
                if (pos[POS_W-1])
                    mapped = '0;
                else if (pos > PAD_HIGH)
                    mapped = MASK;
                else
                    mapped = pos[IW-1:0];
            end
            SPREAD_REFLECT:
            begin
                if (fold > {1'b0, MASK})
                    mapped = IW'(MASK2 - fold);
                else
                    mapped = fold[IW-1:0];
            end
            // repeat, and the unused code behaves the same
            default:
                mapped = pos[IW-1:0] & MASK;
        endcase
    end

    always_comb
    begin
        s4_valid_next = s4_valid_reg;
        s4_tag_next   = s4_tag_reg;
        addr_next     = addr_reg;
        if (in_ready)
        begin
            s4_valid_next = in_valid;
            s4_tag_next   = in_tag;
            addr_next     = mapped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s4_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s4_tag_reg <= s4_tag_next;
        addr_reg   <= addr_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_tag   = s4_tag_reg;
    assign ramp_addr = addr_reg;

    a_addr_in_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_tag_reg.opcode == OP_PIXEL)
            |-> (32'(addr_reg) < 32'(RAMP_LENGTH)))
        else $error("mapped index beyond the ramp");

    a_addr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !out_ready) |=> (s4_valid_reg && $stable(addr_reg)))
        else $error("stalled index changed");

    a_pad_low: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && spread_mode == SPREAD_PAD && acc[ACC_W-1]
            && acc[ACC_W-2:FRAC_W] != {(ACC_W - 1 - FRAC_W){1'b1}})
            |=> (addr_reg == '0))
        else $error("pad of a negative position not clamped to zero");

endmodule

`default_nettype wire

// ===== hw/rtl/lgl_ramp.sv =====
// colour ramp memory and the response output register
// one register stage; depends on lgl_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgl_ramp
    import lgl_pkg::*;
#(
    parameter int RAMP_LENGTH = LGL_RAMP_LENGTH,
    localparam int IW = $clog2(RAMP_LENGTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lgl_tag_t           in_tag,
    input  wire logic [IW-1:0]      ramp_addr,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COLOR_W-1:0]      pixel_color,
    output logic [INDEX_W-1:0]      used_index
);

    logic [COLOR_W-1:0] ramp_mem [RAMP_LENGTH];

    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [COLOR_W-1:0] color_reg;

    logic               advance;
    logic               do_write;
    logic               do_read;
    logic               wr_ok;
    logic [IW-1:0]      wr_addr;

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;
    // writes past the ramp end are dropped
    assign wr_ok    = 32'(in_tag.ramp_index) < 32'(RAMP_LENGTH);
    assign wr_addr  = IW'(in_tag.ramp_index);
    assign do_write = advance && in_tag.opcode == OP_WRITE && wr_ok;
    assign do_read  = advance && in_tag.opcode == OP_PIXEL;

    always_ff @(posedge clk)
    begin
        if (do_write)
            ramp_mem[wr_addr] <= in_tag.ramp_color;
        if (do_read)
            color_reg <= ramp_mem[ramp_addr];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        index_next     = index_reg;
        if (in_ready)
        begin
            out_valid_next = in_valid && in_tag.opcode == OP_PIXEL;
            index_next     = INDEX_W'(ramp_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;
    assign used_index  = index_reg;

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_tag.opcode == OP_WRITE) |=> !out_valid_reg)
        else $error("ramp write produced a response");

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        do_read |=> out_valid_reg)
        else $error("pixel lookup produced no response");

    a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(color_reg))
        else $error("pending colour overwritten");

endmodule

`default_nettype wire
